// ----- rtl/npt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

    // Event codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_END   = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_NOSTART  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Transaction travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic        command;
        logic [31:0] site_id;
        logic [63:0] timestamp;
        logic        found;
        status_t     status;
        logic        closed;
        logic [15:0] nesting;
        logic [31:0] call_total;
        logic [63:0] time_total;
        logic [63:0] elapsed;
    } token_t;

endpackage

`default_nettype wire

// ----- rtl/nested_interval_profiler_table.sv -----
// Path: an accepted transaction passes every cell's hand-off register, then the result register, to out_valid.
// Throughput: one transaction per cycle; each event walks the cell chain one
// slot per cycle, and a stalled result freezes the whole chain.
// Reset (rst_n, async, active low) empties the table and clears both global
// totals; per-slot counters are written when a slot is claimed.
`timescale 1ns / 1ps
`default_nettype none

module nested_interval_profiler_table
    import npt_pkg::*;
#(
    parameter int SITE_SLOTS = 64
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          command,
    input  wire logic [31:0]                   site_id,
    input  wire logic [63:0]                   timestamp,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         status,
    output logic [$clog2(SITE_SLOTS)-1:0]      slot_index,
    output logic                               interval_closed,
    output logic [15:0]                        nesting_level,
    output logic [31:0]                        site_call_total,
    output logic [63:0]                        site_time_total,
    output logic [63:0]                        global_call_total,
    output logic [63:0]                        global_time_total
);

    localparam int IDX_W  = $clog2(SITE_SLOTS);
    localparam int USED_W = $clog2(SITE_SLOTS + 1);

    token_t           tok  [0:SITE_SLOTS];
    logic [IDX_W-1:0] slot [0:SITE_SLOTS];
    logic [SITE_SLOTS-1:0] claim_vec;

    logic              advance;
    logic [USED_W-1:0] slots_used_reg, slots_used_next;
    logic [63:0]       all_calls_reg, all_calls_next;
    logic [63:0]       all_time_reg,  all_time_next;

    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  slot_reg;
    logic              closed_reg;
    logic [15:0]       nesting_reg;
    logic [31:0]       call_reg;
    logic [63:0]       time_reg;

    // Chain moves whenever the result register is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Entry transaction
    always_comb
    begin
        tok[0]           = '0;
        tok[0].valid     = in_valid && advance;
        tok[0].command   = command;
        tok[0].site_id   = site_id;
        tok[0].timestamp = timestamp;
        tok[0].status    = ST_OK;
        slot[0]          = '0;
    end

    // Cell chain, one slot per cell
    for (genvar i = 0; i < SITE_SLOTS; i++)
    begin : g_cell
        npt_cell #(
            .IDX_W  (IDX_W),
            .USED_W (USED_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (IDX_W'(i)),
            .slots_used (slots_used_reg),
            .tok_in     (tok[i]),
            .slot_in    (slot[i]),
            .tok_out    (tok[i+1]),
            .slot_out   (slot[i+1]),
            .claim      (claim_vec[i])
        );
    end

    // Occupancy count and global totals
    always_comb
    begin
        slots_used_next = slots_used_reg + USED_W'(|claim_vec);
        all_calls_next  = all_calls_reg;
        all_time_next   = all_time_reg;
        if (tok[SITE_SLOTS].valid && tok[SITE_SLOTS].closed)
        begin
            all_calls_next = all_calls_reg + 64'd1;
            all_time_next  = all_time_reg + tok[SITE_SLOTS].elapsed;
        end
    end

    // Final status for events that matched no slot
    always_comb
    begin
        status_next = tok[SITE_SLOTS].status;
        if (!tok[SITE_SLOTS].found)
        begin
            status_next = (tok[SITE_SLOTS].command == CMD_START) ? ST_FULL : ST_UNKNOWN;
        end
    end

    // Control and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used_reg <= '0;
            all_calls_reg  <= '0;
            all_time_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            slots_used_reg <= slots_used_next;
            all_calls_reg  <= all_calls_next;
            all_time_reg   <= all_time_next;
            out_valid_reg  <= tok[SITE_SLOTS].valid;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && tok[SITE_SLOTS].valid)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot[SITE_SLOTS];
            closed_reg  <= tok[SITE_SLOTS].closed;
            nesting_reg <= tok[SITE_SLOTS].nesting;
            call_reg    <= tok[SITE_SLOTS].call_total;
            time_reg    <= tok[SITE_SLOTS].time_total;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign slot_index        = slot_reg;
    assign interval_closed   = closed_reg;
    assign nesting_level     = nesting_reg;
    assign site_call_total   = call_reg;
    assign site_time_total   = time_reg;
    assign global_call_total = all_calls_reg;
    assign global_time_total = all_time_reg;

endmodule

`default_nettype wire

// ----- rtl/npt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module npt_cell
    import npt_pkg::*;
#(
    parameter int IDX_W  = 6,
    parameter int USED_W = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic [USED_W-1:0] slots_used,
    input  wire token_t            tok_in,
    input  wire logic [IDX_W-1:0]  slot_in,
    output token_t                 tok_out,
    output logic [IDX_W-1:0]       slot_out,
    output logic                   claim
);

    // Slot state held by this cell
    logic [31:0] key_reg,   key_next;
    logic [15:0] count_reg, count_next;
    logic [63:0] start_reg, start_next;
    logic [63:0] time_reg,  time_next;
    logic [31:0] call_reg,  call_next;

    token_t           tok_reg,  tok_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    logic        used;
    logic        hit;
    logic        fresh;
    logic [15:0] count_inc;
    logic [15:0] count_dec;
    logic [63:0] elapsed;

    // Slot occupancy, match and claim decisions
    assign used  = slots_used > USED_W'(cell_index);
    assign hit   = tok_in.valid && !tok_in.found && used && (key_reg == tok_in.site_id);
    assign fresh = tok_in.valid && !tok_in.found && (slots_used == USED_W'(cell_index))
                   && (tok_in.command == CMD_START);
    assign count_inc = count_reg + 16'd1;
    assign count_dec = count_reg - 16'd1;
    assign elapsed   = tok_in.timestamp - start_reg;
    assign claim     = advance && fresh;

    // Event processing for the slot held here
    always_comb
    begin
        tok_next   = tok_in;
        slot_next  = slot_in;
        key_next   = key_reg;
        count_next = count_reg;
        start_next = start_reg;
        time_next  = time_reg;
        call_next  = call_reg;
        if (hit)
        begin
            tok_next.found      = 1'b1;
            tok_next.status     = ST_OK;
            tok_next.nesting    = count_reg;
            tok_next.call_total = call_reg;
            tok_next.time_total = time_reg;
            slot_next           = cell_index;
            if (tok_in.command == CMD_START)
            begin
                if (count_reg == COUNT_MAX)
                begin
                    tok_next.status = ST_OVERFLOW;
                end
                else
                begin
                    count_next       = count_inc;
                    tok_next.nesting = count_inc;
                    if (count_reg == 16'd0)
                    begin
                        start_next = tok_in.timestamp;
                    end
                end
            end
            else
            begin
                if (count_reg == 16'd0)
                begin
                    tok_next.status = ST_NOSTART;
                end
                else
                begin
                    count_next       = count_dec;
                    tok_next.nesting = count_dec;
                    if (count_reg == 16'd1)
                    begin
                        time_next           = time_reg + elapsed;
                        call_next           = call_reg + 32'd1;
                        tok_next.closed     = 1'b1;
                        tok_next.elapsed    = elapsed;
                        tok_next.time_total = time_reg + elapsed;
                        tok_next.call_total = call_reg + 32'd1;
                    end
                end
            end
        end
        else if (fresh)
        begin
            key_next            = tok_in.site_id;
            count_next          = 16'd1;
            start_next          = tok_in.timestamp;
            time_next           = 64'd0;
            call_next           = 32'd0;
            tok_next.found      = 1'b1;
            tok_next.status     = ST_OK;
            tok_next.nesting    = 16'd1;
            tok_next.call_total = 32'd0;
            tok_next.time_total = 64'd0;
            slot_next           = cell_index;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg   <= key_next;
            count_reg <= count_next;
            start_reg <= start_next;
            time_reg  <= time_next;
            call_reg  <= call_next;
            slot_reg  <= slot_next;
        end
    end

    // Hand-off register to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

`default_nettype wire

// ----- rtl/npt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module npt_checker
    import npt_pkg::*;
#(
    parameter int SITE_SLOTS = 64
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [2:0]                    status,
    input  wire logic [$clog2(SITE_SLOTS)-1:0] slot_index,
    input  wire logic                          interval_closed,
    input  wire logic [15:0]                   nesting_level,
    input  wire logic [31:0]                   site_call_total,
    input  wire logic [63:0]                   site_time_total
);

    // Input side only stalls behind a blocked result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    // An error never closes an interval
    a_err_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> !interval_closed)
        else $error("interval closed on error status");

    // Closing leaves the site with no open starts
    a_close_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && interval_closed) |-> (nesting_level == 16'd0))
        else $error("closed interval with open nesting");

    // No slot found: slot fields read zero
    a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL || status == ST_UNKNOWN)) |->
        (slot_index == '0 && nesting_level == 16'd0 &&
         site_call_total == 32'd0 && site_time_total == 64'd0))
        else $error("slot fields nonzero without a slot");

endmodule

bind nested_interval_profiler_table npt_checker #(.SITE_SLOTS(SITE_SLOTS)) u_npt_checker (.*);

`default_nettype wire

// ----- test/profile_checker.sv -----
`timescale 1ns / 1ps

module profile_checker
    import npt_pkg::*;
#(
    parameter int SITE_SLOTS = 64
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          command,
    input  wire logic [31:0]                   site_id,
    input  wire logic [63:0]                   timestamp,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [2:0]                    status,
    input  wire logic [$clog2(SITE_SLOTS)-1:0] slot_index,
    input  wire logic                          interval_closed,
    input  wire logic [15:0]                   nesting_level,
    input  wire logic [31:0]                   site_call_total,
    input  wire logic [63:0]                   site_time_total,
    input  wire logic [63:0]                   global_call_total,
    input  wire logic [63:0]                   global_time_total,
    output int                                 mismatches,
    output int                                 outstanding
);

    localparam int IDX_W = $clog2(SITE_SLOTS);

    typedef struct {
        status_t          status;
        logic [IDX_W-1:0] slot;
        logic             closed;
        logic [15:0]      nesting;
        logic [31:0]      site_calls;
        logic [63:0]      site_time;
        logic [63:0]      all_calls;
        logic [63:0]      all_time;
    } profile_report_t;

    // Predicted table contents
    logic [31:0] site_key    [SITE_SLOTS];
    logic [15:0] open_depth  [SITE_SLOTS];
    logic [63:0] opened_at   [SITE_SLOTS];
    logic [63:0] site_time   [SITE_SLOTS];
    logic [31:0] site_calls  [SITE_SLOTS];
    int          used_slots;
    logic [63:0] total_calls;
    logic [63:0] grand_time;

    profile_report_t expected_reports[$];
    profile_report_t want;
    profile_report_t got;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Apply one start/end event to the predicted table and build its report
    task automatic apply_profile_event(input logic cmd, input logic [31:0] key,
                                       input logic [63:0] now,
                                       output profile_report_t rep);
        int          slot;
        status_t     st;
        logic        closed;
        logic [63:0] elapsed;
        slot   = -1;
        st     = ST_OK;
        closed = 1'b0;
        for (int i = 0; i < used_slots; i++)
            if (slot < 0 && site_key[i] == key)
                slot = i;

        if (cmd == CMD_START)
        begin
            if (slot < 0 && used_slots >= SITE_SLOTS)
                st = ST_FULL;
            else
            begin
                // new site claims the next free slot, cleared
                if (slot < 0)
                begin
                    slot             = used_slots;
                    used_slots       = used_slots + 1;
                    site_key[slot]   = key;
                    open_depth[slot] = '0;
                    opened_at[slot]  = '0;
                    site_time[slot]  = '0;
                    site_calls[slot] = '0;
                end
                if (open_depth[slot] == COUNT_MAX)
                    st = ST_OVERFLOW;
                else
                begin
                    open_depth[slot] = open_depth[slot] + 16'd1;
                    if (open_depth[slot] == 16'd1)
                        opened_at[slot] = now;
                end
            end
        end
        else
        begin
            if (slot < 0)
                st = ST_UNKNOWN;
            else if (open_depth[slot] == '0)
                st = ST_NOSTART;
            else
            begin
                open_depth[slot] = open_depth[slot] - 16'd1;
                // outermost interval closes: accumulate
                if (open_depth[slot] == '0)
                begin
                    elapsed          = now - opened_at[slot];
                    site_time[slot]  = site_time[slot] + elapsed;
                    grand_time       = grand_time + elapsed;
                    site_calls[slot] = site_calls[slot] + 32'd1;
                    total_calls      = total_calls + 64'd1;
                    closed           = 1'b1;
                end
            end
        end

        rep.status    = st;
        rep.closed    = closed;
        rep.all_calls = total_calls;
        rep.all_time  = grand_time;
        if (slot >= 0)
        begin
            rep.slot       = slot[IDX_W-1:0];
            rep.nesting    = open_depth[slot];
            rep.site_calls = site_calls[slot];
            rep.site_time  = site_time[slot];
        end
        else
        begin
            rep.slot       = '0;
            rep.nesting    = '0;
            rep.site_calls = '0;
            rep.site_time  = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            if (mismatches < 10)
                $display("%0t ns: %s mismatch, expected %h, got %h",
                         $time, name, want_v, got_v);
            mismatches = mismatches + 1;
        end
    endtask

    // Compare outgoing transactions, then predict incoming ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_slots  = 0;
            total_calls = '0;
            grand_time  = '0;
            expected_reports.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t ns: result with no transaction outstanding", $time);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("slot_index", 64'(want.slot), 64'(slot_index));
                    check_field("interval_closed", 64'(want.closed), 64'(interval_closed));
                    check_field("nesting_level", 64'(want.nesting), 64'(nesting_level));
                    check_field("site_call_total", 64'(want.site_calls),
                                64'(site_call_total));
                    check_field("site_time_total", want.site_time, site_time_total);
                    check_field("global_call_total", want.all_calls, global_call_total);
                    check_field("global_time_total", want.all_time, global_time_total);
                end
            end
            if (in_valid && in_ready)
            begin
                apply_profile_event(command, site_id, timestamp, got);
                expected_reports.push_back(got);
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import npt_pkg::*;

    localparam int     SITE_SLOTS   = 64;
    localparam int     IDX_W        = $clog2(SITE_SLOTS);
    localparam int     CLK_PERIOD   = 4;
    localparam int     POOL_SIZE    = 40;
    localparam int     RANDOM_ITEMS = 350;
    localparam int     FILL_ITEMS   = 70;
    localparam int     DEEP_LEVELS  = 40;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 2 * SITE_SLOTS + 10;
    localparam longint TIMEOUT_NS   = 64'd20_000_000;
    localparam logic [31:0] DEEP_SITE = 32'h5A5A_0F0F;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             command   = CMD_START;
    logic [31:0]      site_id   = '0;
    logic [63:0]      timestamp = '0;
    logic             out_ready = 1'b0;
    logic             in_ready;
    logic             out_valid;
    logic [2:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic             interval_closed;
    logic [15:0]      nesting_level;
    logic [31:0]      site_call_total;
    logic [63:0]      site_time_total;
    logic [63:0]      global_call_total;
    logic [63:0]      global_time_total;

    int          mismatches;
    int          outstanding;
    logic        src_idle_on  = 1'b0;
    logic        sink_idle_on = 1'b0;
    logic        hold_req     = 1'b0;
    logic [63:0] clock_us;
    logic [31:0] site_pool [POOL_SIZE];

    always #(CLK_PERIOD / 2) clk = ~clk;

    nested_interval_profiler_table #(
        .SITE_SLOTS (SITE_SLOTS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .site_id           (site_id),
        .timestamp         (timestamp),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .slot_index        (slot_index),
        .interval_closed   (interval_closed),
        .nesting_level     (nesting_level),
        .site_call_total   (site_call_total),
        .site_time_total   (site_time_total),
        .global_call_total (global_call_total),
        .global_time_total (global_time_total)
    );

    profile_checker #(
        .SITE_SLOTS (SITE_SLOTS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .site_id           (site_id),
        .timestamp         (timestamp),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .slot_index        (slot_index),
        .interval_closed   (interval_closed),
        .nesting_level     (nesting_level),
        .site_call_total   (site_call_total),
        .site_time_total   (site_time_total),
        .global_call_total (global_call_total),
        .global_time_total (global_time_total),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // Offer one transaction; called at a falling edge, returns at one
    task automatic send_event(input logic cmd, input logic [31:0] key,
                              input logic [63:0] now);
        while (src_idle_on && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        site_id   <= key;
        timestamp <= now;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Pool sites mostly, some fresh ids; clock mostly advancing, some arbitrary
    task automatic send_random_event();
        logic        cmd;
        logic [31:0] key;
        logic [63:0] now;
        cmd = 1'($urandom_range(1));
        if ($urandom_range(99) < 8)
            key = $urandom();
        else
            key = site_pool[$urandom_range(POOL_SIZE - 1)];
        clock_us = clock_us + $urandom_range(5000);
        if ($urandom_range(99) < 15)
            now = {$urandom(), $urandom()};
        else
            now = clock_us;
        send_event(cmd, key, now);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Result side: random stalls, or a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (sink_idle_on)
                out_ready <= ($urandom_range(99) >= 33);
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("nested_interval_profiler_table verification failed");
        $finish;
    end

    initial
    begin
        site_pool[0] = 32'h0000_0000;
        site_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            site_pool[i] = $urandom();
        // start near the top so the running clock wraps during the run
        clock_us = 64'hFFFF_FFFF_FFF0_0000;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unknown site, extremes of ids and times, wrapping elapsed
        send_event(CMD_END,   32'h0000_0000, 64'h0);
        send_event(CMD_START, 32'h0000_0000, 64'h0);
        send_event(CMD_END,   32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(CMD_END,   32'h0000_0000, 64'h0);
        send_event(CMD_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(CMD_START, 32'hFFFF_FFFF, 64'h0);
        send_event(CMD_END,   32'hFFFF_FFFF, 64'h1);
        send_event(CMD_END,   32'hFFFF_FFFF, 64'h2);
        send_event(CMD_START, 32'h8000_0001, 64'h8000_0000_0000_0000);
        send_event(CMD_START, 32'h8000_0001, 64'h1);
        send_event(CMD_END,   32'h8000_0001, 64'h2);
        send_event(CMD_START, 32'h8000_0001, 64'h3);
        send_event(CMD_END,   32'h8000_0001, 64'h4);
        send_event(CMD_END,   32'h8000_0001, 64'h7FFF_FFFF_FFFF_FFFF);
        send_event(CMD_END,   32'h8000_0001, 64'h5);
        send_event(CMD_END,   32'h1234_5678, 64'h6);
        send_event(CMD_START, 32'h0000_0000, 64'd10);
        send_event(CMD_END,   32'h0000_0000, 64'd25);

        // sender pauses until everything is back
        wait_drained();

        // Deep nesting on one site, back to back with no stalls
        for (int n = 0; n < DEEP_LEVELS; n++)
            send_event(CMD_START, DEEP_SITE, 64'd1000 + n);
        send_event(CMD_START, DEEP_SITE, 64'd70000);
        send_event(CMD_START, DEEP_SITE, 64'd70001);
        send_event(CMD_END,   DEEP_SITE, 64'd70002);
        send_event(CMD_START, DEEP_SITE, 64'd70003);
        send_event(CMD_START, DEEP_SITE, 64'd70004);
        send_event(CMD_END,   DEEP_SITE, 64'd70005);

        // Random traffic with stalls on both sides, one long result hold-off
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                hold_req    = 1'b1;
                src_idle_on = 1'b0;
            end
            if (i == RANDOM_ITEMS / 2 + 100)
                src_idle_on = 1'b1;
            send_random_event();
        end

        // Fresh sites until the table is full and starts get refused
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            clock_us = clock_us + $urandom_range(5000);
            send_event(CMD_START, $urandom(), clock_us);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random_event();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("nested_interval_profiler_table verification clean");
        else
            $display("nested_interval_profiler_table verification failed");
        $finish;
    end

endmodule
